// ===== rtl/pest_pkg.sv =====
// ----------------------------------------------------------------------------
// pest_pkg
// Shared types and codes for the priority event slot table.
// ----------------------------------------------------------------------------
package pest_pkg;

   // Width of slot index fields on the ports
   localparam int SLOT_INDEX_W = 6;

   // Configuration port
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 3;
   localparam logic [CSR_INDEX_W-1:0] CSR_ACCEPT_ENABLE = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TOP_PRIORITY  = 1'd1;
   localparam logic [2:0] TOP_PRIORITY_RESET = 3'd7;

   // Result status codes
   localparam logic STATUS_OK   = 1'b0;
   localparam logic STATUS_FAIL = 1'b1;

   // Operation codes
   typedef enum logic [1:0] {
      OP_POST,
      OP_CLEAR,
      OP_GET,
      OP_DELETE_ALL
   } op_type;

   // One stored event
   typedef struct packed {
      logic [7:0]  code;
      logic [7:0]  source;
      logic [2:0]  prio;
      logic [31:0] length;
      logic [31:0] value;
      logic [31:0] handle;
   } slot_entry_type;

   // One result item
   typedef struct packed {
      logic                    status;
      logic [SLOT_INDEX_W-1:0] index;
      slot_entry_type          entry;
   } result_type;

endpackage

// ===== rtl/pest_slot_mem.sv =====
// ----------------------------------------------------------------------------
// pest_slot_mem
// Slot storage: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module pest_slot_mem
   import pest_pkg::*;
#(
   parameter int DEPTH = 16,
   parameter int AW    = 4
) (
   input  logic           clock,
   input  logic           wr_en,
   input  logic [AW-1:0]  wr_addr,
   input  slot_entry_type wr_data,
   input  logic           rd_en,
   input  logic [AW-1:0]  rd_addr,
   output slot_entry_type rd_data
);

   slot_entry_type mem [DEPTH];
   slot_entry_type rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/pest_engine.sv =====
// ----------------------------------------------------------------------------
// pest_engine
// Operation sequencer: occupancy flags, slot walk for post and get, and the
// match/priority compare unit used by get, fed by the slot memory read port.
// ----------------------------------------------------------------------------
module pest_engine
   import pest_pkg::*;
#(
   parameter int SLOT_COUNT = 16,
   parameter int IDX_W      = 4
) (
   input  logic             clock,
   input  logic             reset,
   // new item
   input  logic             start,
   input  op_type           req_op,
   input  slot_entry_type   req_entry,
   input  logic [5:0]       req_sel,
   input  logic [7:0]       req_mask,
   // configuration
   input  logic             accept_enable,
   input  logic [2:0]       top_priority,
   // status / result
   output logic             busy,
   output logic             res_valid,
   output result_type       res,
   input  logic             res_take,
   // slot memory
   output logic             mem_wr_en,
   output logic [IDX_W-1:0] mem_wr_addr,
   output slot_entry_type   mem_wr_data,
   output logic             mem_rd_en,
   output logic [IDX_W-1:0] mem_rd_addr,
   input  slot_entry_type   mem_rd_data
);

   localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(SLOT_COUNT - 1);
   localparam logic [SLOT_INDEX_W:0] SEL_LIMIT = (SLOT_INDEX_W + 1)'(SLOT_COUNT);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_POST,
      ST_GET,
      ST_DONE
   } state_type;

   // control state
   state_type              state_ff,       state_in;
   logic [IDX_W-1:0]       k_ff,           k_in;
   logic                   issue_done_ff,  issue_done_in;
   logic                   cmp_vld_ff,     cmp_vld_in;
   logic [IDX_W-1:0]       cmp_idx_ff,     cmp_idx_in;
   logic [SLOT_COUNT-1:0]  occ_ff,         occ_in;
   logic                   best_found_ff,  best_found_in;

   // datapath
   logic [2:0]             best_pri_ff,    best_pri_in;
   logic [IDX_W-1:0]       best_idx_ff,    best_idx_in;
   slot_entry_type         best_entry_ff,  best_entry_in;
   slot_entry_type         item_ff,        item_in;
   logic [7:0]             mask_ff,        mask_in;
   result_type             res_ff,         res_in;

   // compare unit
   logic                   cmp_match;
   logic                   cmp_hit;

   always_comb begin
      cmp_match = cmp_vld_ff && occ_ff[cmp_idx_ff]
                  && (!best_found_ff || (mem_rd_data.prio > best_pri_ff))
                  && ((mem_rd_data.source & mask_ff) != 8'd0);
      cmp_hit   = cmp_match && (mem_rd_data.prio >= top_priority);
   end

   // Next-state logic
   always_comb begin
      state_in      = state_ff;
      k_in          = k_ff;
      issue_done_in = issue_done_ff;
      cmp_vld_in    = 1'b0;
      cmp_idx_in    = cmp_idx_ff;
      occ_in        = occ_ff;
      best_found_in = best_found_ff;
      best_pri_in   = best_pri_ff;
      best_idx_in   = best_idx_ff;
      best_entry_in = best_entry_ff;
      item_in       = item_ff;
      mask_in       = mask_ff;
      res_in        = res_ff;
      mem_wr_en     = 1'b0;
      mem_rd_en     = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               item_in       = req_entry;
               mask_in       = req_mask;
               k_in          = '0;
               issue_done_in = 1'b0;
               best_found_in = 1'b0;
               res_in        = '0;
               state_in      = ST_DONE;
               case (req_op)
                  OP_POST: begin
                     if (accept_enable) begin
                        state_in = ST_POST;
                     end else begin
                        res_in.status = STATUS_FAIL;
                     end
                  end
                  OP_CLEAR: begin
                     if ({1'b0, req_sel} < SEL_LIMIT) begin
                        occ_in[req_sel[IDX_W-1:0]] = 1'b0;
                        res_in.index = req_sel;
                     end else begin
                        res_in.status = STATUS_FAIL;
                     end
                  end
                  OP_GET: begin
                     if (accept_enable) begin
                        state_in = ST_GET;
                     end else begin
                        res_in.status = STATUS_FAIL;
                     end
                  end
                  OP_DELETE_ALL: begin
                     occ_in = '0;
                  end
                  default: begin
                     res_in.status = STATUS_FAIL;
                  end
               endcase
            end
         end

         // walk flags for the lowest empty slot
         ST_POST: begin
            if (!occ_ff[k_ff]) begin
               mem_wr_en     = 1'b1;
               occ_in[k_ff]  = (item_ff.code != 8'd0);
               res_in.status = STATUS_OK;
               res_in.index  = SLOT_INDEX_W'(k_ff);
               state_in      = ST_DONE;
            end else if (k_ff == LAST_SLOT) begin
               res_in.status = STATUS_FAIL;
               state_in      = ST_DONE;
            end else begin
               k_in = k_ff + 1'b1;
            end
         end

         // read one slot per cycle, compare it in the cycle after its read
         ST_GET: begin
            if (!issue_done_ff) begin
               mem_rd_en  = 1'b1;
               cmp_vld_in = 1'b1;
               cmp_idx_in = k_ff;
               if (k_ff == LAST_SLOT) begin
                  issue_done_in = 1'b1;
               end else begin
                  k_in = k_ff + 1'b1;
               end
            end
            if (cmp_match) begin
               best_found_in = 1'b1;
               best_pri_in   = mem_rd_data.prio;
               best_idx_in   = cmp_idx_ff;
               best_entry_in = mem_rd_data;
            end
            if (cmp_vld_ff && (cmp_hit || (cmp_idx_ff == LAST_SLOT))) begin
               cmp_vld_in = 1'b0;
               state_in   = ST_DONE;
               if (cmp_match) begin
                  res_in.status = STATUS_OK;
                  res_in.index  = SLOT_INDEX_W'(cmp_idx_ff);
                  res_in.entry  = mem_rd_data;
               end else if (best_found_ff) begin
                  res_in.status = STATUS_OK;
                  res_in.index  = SLOT_INDEX_W'(best_idx_ff);
                  res_in.entry  = best_entry_ff;
               end else begin
                  res_in.status = STATUS_FAIL;
               end
            end
         end

         ST_DONE: begin
            if (res_take) begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         k_ff          <= '0;
         issue_done_ff <= 1'b0;
         cmp_vld_ff    <= 1'b0;
         cmp_idx_ff    <= '0;
         occ_ff        <= '0;
         best_found_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         k_ff          <= k_in;
         issue_done_ff <= issue_done_in;
         cmp_vld_ff    <= cmp_vld_in;
         cmp_idx_ff    <= cmp_idx_in;
         occ_ff        <= occ_in;
         best_found_ff <= best_found_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      best_pri_ff   <= best_pri_in;
      best_idx_ff   <= best_idx_in;
      best_entry_ff <= best_entry_in;
      item_ff       <= item_in;
      mask_ff       <= mask_in;
      res_ff        <= res_in;
   end

   assign busy        = (state_ff != ST_IDLE);
   assign res_valid   = (state_ff == ST_DONE);
   assign res         = res_ff;
   assign mem_wr_addr = k_ff;
   assign mem_wr_data = item_ff;
   assign mem_rd_addr = k_ff;

   // Checks
   a_no_rw_overlap: assert property (@(posedge clock) disable iff (reset)
      !(mem_wr_en && mem_rd_en))
      else $error("slot memory written and read in one cycle");

   a_cmp_only_in_get: assert property (@(posedge clock) disable iff (reset)
      cmp_vld_ff |-> (state_ff == ST_GET))
      else $error("compare stage active outside get");

   a_start_when_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> (state_ff == ST_IDLE))
      else $error("item started while busy");

   a_post_finishes: assert property (@(posedge clock) disable iff (reset)
      mem_wr_en |=> (state_ff == ST_DONE) && (res_ff.status == STATUS_OK))
      else $error("post wrote a slot without reporting it");

   a_get_returns_occupied: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_GET) && (state_in == ST_DONE) && (res_in.status == STATUS_OK))
      |-> occ_ff[res_in.index[IDX_W-1:0]])
      else $error("get returned an empty slot");

endmodule

// ===== rtl/priority_event_slot_table_core.sv =====
// ----------------------------------------------------------------------------
// priority_event_slot_table_core
// Event slot table with post, clear, get-best and delete-all operations.
// ----------------------------------------------------------------------------
// One item at a time. Clear and delete-all go straight to the result state.
// Post walks the occupancy flags one slot per cycle up to the lowest free slot
// and fails on a full table. Get reads the slot memory one slot per cycle
// through its single registered read port and compares each slot in the cycle
// after its read, ending early when a slot at or above the top priority level
// is found. A finished result moves into the output register; the next item is
// taken once the sequencer has handed its result over. Slot contents other than
// the occupancy flags are not reset; delete-all clears all flags at once.
// ----------------------------------------------------------------------------
module priority_event_slot_table_core
   import pest_pkg::*;
#(
   parameter int SLOT_COUNT = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   // input item channel
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [1:0]             req_operation,
   input  logic [7:0]             req_event_code,
   input  logic [7:0]             req_source_bits,
   input  logic [2:0]             req_priority_level,
   input  logic [31:0]            req_payload_length,
   input  logic [31:0]            req_payload_value,
   input  logic [31:0]            req_payload_handle,
   input  logic [5:0]             req_slot_select,
   input  logic [7:0]             req_source_mask,
   // result channel
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic                   rsp_status,
   output logic [5:0]             rsp_slot_index,
   output logic [7:0]             rsp_event_code_out,
   output logic [7:0]             rsp_source_out,
   output logic [2:0]             rsp_priority_out,
   output logic [31:0]            rsp_length_out,
   output logic [31:0]            rsp_value_out,
   output logic [31:0]            rsp_handle_out,
   // configuration
   input  logic                   csr_write,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int IDX_W = $clog2(SLOT_COUNT);

   logic             accept_enable_ff, accept_enable_in;
   logic [2:0]       top_priority_ff,  top_priority_in;
   logic             rsp_valid_ff,     rsp_valid_in;
   result_type       rsp_ff,           rsp_in;

   logic             start;
   logic             busy;
   logic             res_valid;
   logic             res_take;
   result_type       res;
   slot_entry_type   req_entry;
   logic             mem_wr_en;
   logic [IDX_W-1:0] mem_wr_addr;
   slot_entry_type   mem_wr_data;
   logic             mem_rd_en;
   logic [IDX_W-1:0] mem_rd_addr;
   slot_entry_type   mem_rd_data;

   // Input handshake
   assign req_stall = busy;
   assign start     = req_valid && !busy;

   always_comb begin
      req_entry.code   = req_event_code;
      req_entry.source = req_source_bits;
      req_entry.prio   = req_priority_level;
      req_entry.length = req_payload_length;
      req_entry.value  = req_payload_value;
      req_entry.handle = req_payload_handle;
   end

   // Configuration registers
   always_comb begin
      accept_enable_in = accept_enable_ff;
      top_priority_in  = top_priority_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_ACCEPT_ENABLE: accept_enable_in = csr_wdata[0];
            CSR_TOP_PRIORITY:  top_priority_in  = csr_wdata[2:0];
            default: begin
            end
         endcase
      end
   end

   // Output register
   assign res_take = res_valid && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      if (res_take) begin
         rsp_valid_in = 1'b1;
         rsp_in       = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         accept_enable_ff <= 1'b0;
         top_priority_ff  <= TOP_PRIORITY_RESET;
         rsp_valid_ff     <= 1'b0;
      end else begin
         accept_enable_ff <= accept_enable_in;
         top_priority_ff  <= top_priority_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   pest_slot_mem #(
      .DEPTH (SLOT_COUNT),
      .AW    (IDX_W)
   ) u_slot_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   pest_engine #(
      .SLOT_COUNT (SLOT_COUNT),
      .IDX_W      (IDX_W)
   ) u_engine (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .req_op        (op_type'(req_operation)),
      .req_entry     (req_entry),
      .req_sel       (req_slot_select),
      .req_mask      (req_source_mask),
      .accept_enable (accept_enable_ff),
      .top_priority  (top_priority_ff),
      .busy          (busy),
      .res_valid     (res_valid),
      .res           (res),
      .res_take      (res_take),
      .mem_wr_en     (mem_wr_en),
      .mem_wr_addr   (mem_wr_addr),
      .mem_wr_data   (mem_wr_data),
      .mem_rd_en     (mem_rd_en),
      .mem_rd_addr   (mem_rd_addr),
      .mem_rd_data   (mem_rd_data)
   );

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_ff.status;
   assign rsp_slot_index     = rsp_ff.index;
   assign rsp_event_code_out = rsp_ff.entry.code;
   assign rsp_source_out     = rsp_ff.entry.source;
   assign rsp_priority_out   = rsp_ff.entry.prio;
   assign rsp_length_out     = rsp_ff.entry.length;
   assign rsp_value_out      = rsp_ff.entry.value;
   assign rsp_handle_out     = rsp_ff.entry.handle;

endmodule
